// ===== design/rtf_pkg.sv =====
// Shared types and constants for the two-pair rigid transform estimator.
package rtf_pkg;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] shift_t;

  // quotient bits resolved by the translation divider, and its register count
  localparam int QUOT_BITS = 33;
  localparam int DIV_LAT = QUOT_BITS + 2;

  // angle unit registers besides its rotation stages: abs, msb search, scale, round
  localparam int ANGLE_EXTRA = 4;

  // vector magnitudes are scaled below 2^LIM_BIT before the rotation stages
  localparam int LIM_BIT = 30;
  localparam int CORDIC_W = 34;
  localparam int ROT_W = 33;

  localparam logic signed [ROT_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
  localparam q14_t Q14_ONE = 16'sd16384;

endpackage

// ===== design/rtf_div.sv =====
// Pipelined restoring divider: rounded, saturated translation quotient.
module rtf_div #(
  parameter int NUM_BITS = 78,
  parameter int DEN_BITS = 51
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [DEN_BITS-1:0]  den_i,
  input  logic                 neg_i,
  output rtf_pkg::shift_t      quot_o
);
  import rtf_pkg::*;

  localparam int RW = (NUM_BITS > DEN_BITS + QUOT_BITS) ? NUM_BITS : DEN_BITS + QUOT_BITS;

  logic [RW-1:0]        rem_q [QUOT_BITS+1];
  logic [DEN_BITS-1:0]  den_q [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quo_q [QUOT_BITS+1];
  logic                 neg_q [QUOT_BITS+1];
  logic                 ovf_q [QUOT_BITS+1];
  shift_t               res_q;

  // quotient does not fit in QUOT_BITS: saturate regardless of the bits below
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= RW'(num_i) >= (RW'(den_i) << QUOT_BITS);
    end
  end

  for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_bit
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(den_q[j-1]) << (QUOT_BITS - j);
    assign ge    = rem_q[j-1] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? rem_q[j-1] - trial : rem_q[j-1];
        den_q[j] <= den_q[j-1];
        quo_q[j] <= {quo_q[j-1][QUOT_BITS-2:0], ge};
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  logic [QUOT_BITS-1:0] lim;
  logic [QUOT_BITS-1:0] mag;

  always_comb begin
    lim = neg_q[QUOT_BITS] ? (QUOT_BITS'(1) << 31) : ((QUOT_BITS'(1) << 31) - QUOT_BITS'(1));
    mag = (ovf_q[QUOT_BITS] || quo_q[QUOT_BITS] > lim) ? lim : quo_q[QUOT_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= neg_q[QUOT_BITS] ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    end
  end

  assign quot_o = res_q;

endmodule

// ===== design/rtf_angle.sv =====
// Pipelined CORDIC: atan2 by vectoring, replayed as rotation to give cos and sin in Q2.14.
module rtf_angle #(
  parameter int N_BITS = 51,
  parameter int STAGES = 16,
  parameter int DELAY  = 1
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [N_BITS-1:0] n0_i,
  input  logic signed [N_BITS-1:0] n1_i,
  output rtf_pkg::q14_t            cos_o,
  output rtf_pkg::q14_t            sin_o
);
  import rtf_pkg::*;

  localparam int MW  = N_BITS - 1;
  localparam int SHW = $clog2(MW);

  // magnitudes
  logic [MW-1:0] m0_q, m1_q, m0b_q, m1b_q;
  logic          ng0_q, ng1_q, ng0b_q, ng1b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ng0_q <= n0_i[N_BITS-1];
      ng1_q <= n1_i[N_BITS-1];
      m0_q  <= n0_i[N_BITS-1] ? MW'(-n0_i) : MW'(n0_i);
      m1_q  <= n1_i[N_BITS-1] ? MW'(-n1_i) : MW'(n1_i);
    end
  end

  // common scale so both magnitudes drop below 2^LIM_BIT
  logic [MW-1:0]  orv;
  logic [SHW-1:0] top;
  logic [SHW-1:0] sh_d, sh_q;

  always_comb begin
    orv = m0_q | m1_q;
    top = '0;
    for (int i = 0; i < MW; i++) begin
      if (orv[i]) top = SHW'(i);
    end
    sh_d = (top >= SHW'(LIM_BIT)) ? top - SHW'(LIM_BIT - 1) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_q   <= sh_d;
      m0b_q  <= m0_q;
      m1b_q  <= m1_q;
      ng0b_q <= ng0_q;
      ng1b_q <= ng1_q;
    end
  end

  logic signed [CORDIC_W-1:0] x_q  [STAGES+1];
  logic signed [CORDIC_W-1:0] y_q  [STAGES+1];
  logic signed [ROT_W-1:0]    cx_q [STAGES+1];
  logic signed [ROT_W-1:0]    cy_q [STAGES+1];
  logic                       zr_q [STAGES+1];
  logic                       fl_q [STAGES+1];

  logic signed [CORDIC_W-1:0] s0, s1;
  logic                       flip;

  // left half-plane vectors turn by 180 degrees; undone after rounding
  always_comb begin
    s0   = $signed(CORDIC_W'(m0b_q >> sh_q));
    s1   = $signed(CORDIC_W'(m1b_q >> sh_q));
    flip = ng0b_q && (s0 != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= s0;
      y_q[0]  <= (ng1b_q ^ flip) ? -s1 : s1;
      cx_q[0] <= INV_GAIN_Q30;
      cy_q[0] <= '0;
      zr_q[0] <= (s0 == '0) && (s1 == '0);
      fl_q[0] <= flip;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic                       dir;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ROT_W-1:0]    cxs, cys;
    assign dir = ~y_q[i][CORDIC_W-1];
    assign xs  = x_q[i] >>> i;
    assign ys  = y_q[i] >>> i;
    assign cxs = cx_q[i] >>> i;
    assign cys = cy_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]  <= dir ? x_q[i] + ys : x_q[i] - ys;
        y_q[i+1]  <= dir ? y_q[i] - xs : y_q[i] + xs;
        cx_q[i+1] <= dir ? cx_q[i] - cys : cx_q[i] + cys;
        cy_q[i+1] <= dir ? cy_q[i] + cxs : cy_q[i] - cxs;
        zr_q[i+1] <= zr_q[i];
        fl_q[i+1] <= fl_q[i];
      end
    end
  end

  function automatic q14_t round14(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W-1:0] r;
    r = (v + ROT_W'(32768)) >>> 16;
    if (r > ROT_W'(Q14_ONE)) begin
      r = ROT_W'(Q14_ONE);
    end else if (r < -ROT_W'(Q14_ONE)) begin
      r = -ROT_W'(Q14_ONE);
    end
    return q14_t'(r);
  endfunction

  q14_t c_w, s_w;
  q14_t dc_q [DELAY+1];
  q14_t ds_q [DELAY+1];

  always_comb begin
    c_w = round14(cx_q[STAGES]);
    s_w = round14(cy_q[STAGES]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zr_q[STAGES]) begin
        dc_q[0] <= Q14_ONE;
        ds_q[0] <= '0;
      end else if (fl_q[STAGES]) begin
        dc_q[0] <= -c_w;
        ds_q[0] <= -s_w;
      end else begin
        dc_q[0] <= c_w;
        ds_q[0] <= s_w;
      end
    end
  end

  // align with the translation path
  for (genvar k = 1; k <= DELAY; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dc_q[k] <= dc_q[k-1];
        ds_q[k] <= ds_q[k-1];
      end
    end
  end

  assign cos_o = dc_q[DELAY];
  assign sin_o = ds_q[DELAY];

endmodule

// ===== design/rigid_transform_from_two_pairs.sv =====
// Top level of the two-pair rigid transform estimator.
//
// Input channel: in_valid_i/in_ready_o carries one request of two source
// points and their two destination points, signed Q15.8 by default.
// Output channel: out_valid_o/out_ready_i returns one result per request:
// cos and sin of the fitted rotation in Q2.14, the translation in Q23.8
// saturated to 32 bits, and degenerate when the source points coincide
// (all other fields then read zero).
// The translation path, through its multiply/add stages and the 33-stage
// translation divider, decides when a result reaches out_valid_o; the CORDIC
// angle path is shorter and is delayed to match.
// Throughput: one request per cycle while in_ready_o is high; requests enter
// and leave in order. The whole pipeline advances on one enable; a two-entry
// output stage absorbs the request in flight when the receiver stalls, after
// which in_ready_o drops until the spare entry drains.
// Reset empties the pipeline and the output stage; no result is pending.
module rigid_transform_from_two_pairs #(
  parameter int COORD_BITS   = 24,
  parameter int ANGLE_STAGES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] src_ax_i,
  input  logic signed [COORD_BITS-1:0] src_ay_i,
  input  logic signed [COORD_BITS-1:0] src_bx_i,
  input  logic signed [COORD_BITS-1:0] src_by_i,
  input  logic signed [COORD_BITS-1:0] dst_ax_i,
  input  logic signed [COORD_BITS-1:0] dst_ay_i,
  input  logic signed [COORD_BITS-1:0] dst_bx_i,
  input  logic signed [COORD_BITS-1:0] dst_by_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rtf_pkg::q14_t                cos_angle_o,
  output rtf_pkg::q14_t                sin_angle_o,
  output rtf_pkg::shift_t              shift_x_o,
  output rtf_pkg::shift_t              shift_y_o,
  output logic                         degenerate_o
);
  import rtf_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int W      = CW + 1;
  localparam int DW     = 2 * W;
  localparam int NW     = 2 * W + 1;
  localparam int HW     = W + 1 + CW;
  localparam int PPW    = NW + CW;
  localparam int PW     = PPW + 2;
  localparam int NUMW   = PW + 1;
  localparam int TR_LAT = 4 + DIV_LAT;
  localparam int AN_LAT = ANGLE_STAGES + ANGLE_EXTRA;

  typedef struct packed {
    q14_t   cos_angle;
    q14_t   sin_angle;
    shift_t shift_x;
    shift_t shift_y;
    logic   degenerate;
  } res_t;

  logic en;

  // stage 1: differences
  logic                 v1_q;
  logic signed [W-1:0]  dx1_q, dy1_q, dX1_q, dY1_q;
  logic signed [CW-1:0] x1a_q, y1a_q, X1a_q, Y1a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= W'(src_ax_i) - W'(src_bx_i);
      dy1_q <= W'(src_ay_i) - W'(src_by_i);
      dX1_q <= W'(dst_ax_i) - W'(dst_bx_i);
      dY1_q <= W'(dst_ay_i) - W'(dst_by_i);
      x1a_q <= src_ax_i;
      y1a_q <= src_ay_i;
      X1a_q <= dst_ax_i;
      Y1a_q <= dst_ay_i;
    end
  end

  // stage 2: products of differences
  logic                 v2_q;
  logic signed [DW-1:0] sxx_q, syy_q, pXx_q, pYy_q, pYx_q, pXy_q;
  logic signed [CW-1:0] x1b_q, y1b_q, X1b_q, Y1b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sxx_q <= dx1_q * dx1_q;
      syy_q <= dy1_q * dy1_q;
      pXx_q <= dX1_q * dx1_q;
      pYy_q <= dY1_q * dy1_q;
      pYx_q <= dY1_q * dx1_q;
      pXy_q <= dX1_q * dy1_q;
      x1b_q <= x1a_q;
      y1b_q <= y1a_q;
      X1b_q <= X1a_q;
      Y1b_q <= Y1a_q;
    end
  end

  // stage 3: D, N0, N1
  logic                 v3_q;
  logic [DW-1:0]        d3_q;
  logic signed [NW-1:0] n0_q, n1_q;
  logic signed [CW-1:0] x1c_q, y1c_q, X1c_q, Y1c_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q  <= $unsigned(sxx_q) + $unsigned(syy_q);
      n0_q  <= NW'(pXx_q) + NW'(pYy_q);
      n1_q  <= NW'(pYx_q) - NW'(pXy_q);
      x1c_q <= x1b_q;
      y1c_q <= y1b_q;
      X1c_q <= X1b_q;
      Y1c_q <= Y1b_q;
    end
  end

  // stage 4: wide products split in halves
  logic signed [NW-1:0] op_m [6];
  logic signed [CW-1:0] op_c [6];
  logic signed [NW-1:0] md;

  assign md      = $signed({1'b0, d3_q});
  assign op_m[0] = md;
  assign op_c[0] = X1c_q;
  assign op_m[1] = n0_q;
  assign op_c[1] = x1c_q;
  assign op_m[2] = n1_q;
  assign op_c[2] = y1c_q;
  assign op_m[3] = md;
  assign op_c[3] = Y1c_q;
  assign op_m[4] = n1_q;
  assign op_c[4] = x1c_q;
  assign op_m[5] = n0_q;
  assign op_c[5] = y1c_q;

  logic signed [HW-1:0]  pl_q [6];
  logic signed [HW-1:0]  ph_q [6];
  logic signed [PPW-1:0] pf_q [6];
  logic [DW-1:0]         d4_q, d5_q, d6_q;

  for (genvar i = 0; i < 6; i++) begin : g_mul
    always_ff @(posedge clk_i) begin
      if (en) begin
        pl_q[i] <= $signed({1'b0, op_m[i][W-1:0]}) * op_c[i];
        ph_q[i] <= $signed(op_m[i][NW-1:W]) * op_c[i];
        pf_q[i] <= (PPW'(ph_q[i]) <<< W) + PPW'(pl_q[i]);
      end
    end
  end

  // stage 6: translation numerators
  logic signed [PW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d4_q <= d3_q;
      d5_q <= d4_q;
      d6_q <= d5_q;
      nx_q <= PW'(pf_q[0]) - PW'(pf_q[1]) + PW'(pf_q[2]);
      ny_q <= PW'(pf_q[3]) - PW'(pf_q[4]) - PW'(pf_q[5]);
    end
  end

  // stage 7: rounding numerator 2|n| + D over 2D
  logic [NUMW-1:0] numx_q, numy_q;
  logic [NW-1:0]   den_q;
  logic            negx_q, negy_q;
  logic [PW-1:0]   absx, absy;

  always_comb begin
    absx = nx_q[PW-1] ? $unsigned(-nx_q) : $unsigned(nx_q);
    absy = ny_q[PW-1] ? $unsigned(-ny_q) : $unsigned(ny_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx_q <= {absx, 1'b0} + NUMW'(d6_q);
      numy_q <= {absy, 1'b0} + NUMW'(d6_q);
      den_q  <= {d6_q, 1'b0};
      negx_q <= nx_q[PW-1];
      negy_q <= ny_q[PW-1];
    end
  end

  shift_t qx_w, qy_w;
  q14_t   cos_w, sin_w;

  rtf_div #(.NUM_BITS(NUMW), .DEN_BITS(NW)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numx_q),
    .den_i  (den_q),
    .neg_i  (negx_q),
    .quot_o (qx_w)
  );

  rtf_div #(.NUM_BITS(NUMW), .DEN_BITS(NW)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numy_q),
    .den_i  (den_q),
    .neg_i  (negy_q),
    .quot_o (qy_w)
  );

  rtf_angle #(.N_BITS(NW), .STAGES(ANGLE_STAGES), .DELAY(TR_LAT - AN_LAT)) u_angle (
    .clk_i (clk_i),
    .en_i  (en),
    .n0_i  (n0_q),
    .n1_i  (n1_q),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  // valid and degenerate flags beside the stage 4 onward data
  logic ln_v_q  [TR_LAT];
  logic ln_dg_q [TR_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k < TR_LAT; k++) begin
        ln_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      ln_v_q[0] <= v3_q;
      for (int k = 1; k < TR_LAT; k++) begin
        ln_v_q[k] <= ln_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ln_dg_q[0] <= (d3_q == '0);
      for (int k = 1; k < TR_LAT; k++) begin
        ln_dg_q[k] <= ln_dg_q[k-1];
      end
    end
  end

  // output register plus spare entry
  res_t res_d, out_q, sp_q;
  logic out_v_q, sp_v_q;
  logic pv, take, push;

  always_comb begin
    pv                = ln_v_q[TR_LAT-1];
    res_d.degenerate  = ln_dg_q[TR_LAT-1];
    res_d.cos_angle   = res_d.degenerate ? '0 : cos_w;
    res_d.sin_angle   = res_d.degenerate ? '0 : sin_w;
    res_d.shift_x     = res_d.degenerate ? '0 : qx_w;
    res_d.shift_y     = res_d.degenerate ? '0 : qy_w;
  end

  assign en         = ~sp_v_q;
  assign in_ready_o = en;
  assign take       = out_v_q & out_ready_i;
  assign push       = en & pv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sp_v_q  <= 1'b0;
    end else if (sp_v_q) begin
      if (take) begin
        sp_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !take) begin
        sp_v_q <= 1'b1;
      end
      out_v_q <= 1'b1;
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sp_v_q) begin
      if (take) begin
        out_q <= sp_q;
      end
    end else if (push) begin
      if (!out_v_q || take) begin
        out_q <= res_d;
      end else begin
        sp_q <= res_d;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign cos_angle_o  = out_q.cos_angle;
  assign sin_angle_o  = out_q.sin_angle;
  assign shift_x_o    = out_q.shift_x;
  assign shift_y_o    = out_q.shift_y;
  assign degenerate_o = out_q.degenerate;

endmodule

// ===== design/rtf_checker.sv =====
// Port-level checks for the rigid transform estimator, bound to the top level.
module rtf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input rtf_pkg::q14_t   cos_angle_o,
  input rtf_pkg::q14_t   sin_angle_o,
  input rtf_pkg::shift_t shift_x_o,
  input rtf_pkg::shift_t shift_y_o,
  input logic            degenerate_o
);
  import rtf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cos_angle_o) &&
      $stable(sin_angle_o) && $stable(shift_x_o) && $stable(shift_y_o) &&
      $stable(degenerate_o))
    else $error("result changed under stall");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> cos_angle_o == '0 && sin_angle_o == '0 &&
      shift_x_o == '0 && shift_y_o == '0)
    else $error("degenerate result with nonzero fields");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o |-> cos_angle_o <= Q14_ONE && cos_angle_o >= -Q14_ONE &&
      sin_angle_o <= Q14_ONE && sin_angle_o >= -Q14_ONE)
    else $error("cos or sin out of Q2.14 unit range");

  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

endmodule

bind rigid_transform_from_two_pairs rtf_checker u_rtf_checker (.*);
